[rtl/gde_pkg.sv]
// Shared types, command codes and exponential tables for the Gaussian density evaluator.
package gde_pkg;

  localparam int MaxDim = 8;
  localparam int IdxW   = 3;

  // Configuration register indexes.
  localparam logic CFG_DIM      = 1'b0;
  localparam logic CFG_INV_NORM = 1'b1;

  // Input item commands.
  localparam logic [1:0] CMD_LOAD_MEAN = 2'd0;
  localparam logic [1:0] CMD_LOAD_PREC = 2'd1;
  localparam logic [1:0] CMD_COORD     = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_LDMEAN, OP_LDPREC, OP_CENT, OP_M1, OP_M2, OP_M3,
    OP_TERM, OP_ACC, OP_EXP0, OP_EXP1, OP_SCALE, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [IdxW-1:0]   rd_row;
    logic [IdxW-1:0]   rd_col;
    logic [IdxW-1:0]   idx_j;
    logic [IdxW-1:0]   idx_i;
    logic              diag;
    logic [2:0]        scale_b;
  } dp_cmd_t;

  // e^-(k/16) in Q1.32, k = 0..16.
  localparam logic [32:0] FRAC_TAB [17] = '{
    33'd4294967296, 33'd4034748382, 33'd3790295335, 33'd3560652950, 33'd3344923893,
    33'd3142265200, 33'd2951884975, 33'd2773039306, 33'd2605029347, 33'd2447198598,
    33'd2298930330, 33'd2159645183, 33'd2028798896, 33'd1905880184, 33'd1790408741,
    33'd1681933360, 33'd1580030169
  };

  // e^-1, e^-2, e^-4, e^-8, e^-16 in Q0.32.
  localparam logic [31:0] INT_TAB [5] = '{
    32'd1580030169, 32'd581260615, 32'd78665070, 32'd1440801, 32'd483
  };

endpackage

[rtl/gaussian_density_eval.sv]
// A load transaction is taken while the controller is idle. A coordinate j (from 0) runs j+1
// form terms, each with three passes through the single 32x32 multiplier, a term register
// and a saturating add. The last coordinate of a point adds the exponential, the scaling
// by e^-1 to e^-16 and normalization before the result is registered on the output.
// Further items are stalled while a coordinate or the final steps of a point run.
// Reset (synchronous, active low) clears the controller, accumulator, dim to 1 and
// inv_norm to 1.0; the mean and precision stores are undefined until loaded.
module gaussian_density_eval
  import gde_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [2:0]         in_row,
  input  logic [2:0]         in_col,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_density,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  dp_cmd_t cmd;
  logic    cfg_wr;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;

  gde_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cfg_wr     (cfg_wr),
    .cfg_index  (cfg_index),
    .cfg_dim    (cfg_data[3:0]),
    .cmd        (cmd)
  );

  // The datapath holds the result register, so a finished transaction can wait on
  // the output while the next items are taken in.
  gde_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_value      (in_value),
    .cfg_wr        (cfg_wr),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_density   (out_density),
    .out_saturated (out_saturated)
  );

endmodule

[rtl/gde_ctrl.sv]
// Sequencing state machine for the Gaussian density evaluator.
module gde_ctrl
  import gde_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_command,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          cfg_wr,
  input  logic          cfg_index,
  input  logic [3:0]    cfg_dim,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_M1, ST_M2, ST_M3, ST_TERM, ST_ACC, ST_EXP0, ST_EXP1, ST_SCALE, ST_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [3:0]      dim_r, dim_nxt;
  logic [IdxW-1:0] cnt_r, cnt_nxt;
  logic [IdxW-1:0] i_r, i_nxt;
  logic            diag_r, diag_nxt;
  logic [2:0]      b_r, b_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [3:0]      dim_eff;
  logic [3:0]      cnt_inc;

  always_comb begin
    if (dim_r == 4'd0) dim_eff = 4'd1;
    else if (dim_r > 4'(MaxDim)) dim_eff = 4'(MaxDim);
    else dim_eff = dim_r;
  end

  assign cnt_inc = {1'b0, cnt_r} + 4'd1;

  always_comb begin
    state_nxt     = state_r;
    dim_nxt       = (cfg_wr && cfg_index == CFG_DIM) ? cfg_dim : dim_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    diag_nxt      = diag_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_LOAD_MEAN: cmd.op = OP_LDMEAN;
            CMD_LOAD_PREC: cmd.op = OP_LDPREC;
            CMD_COORD: begin
              cmd.op    = OP_CENT;
              diag_nxt  = 1'b1;
              i_nxt     = '0;
              state_nxt = ST_M1;
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      ST_M1:   begin cmd.op = OP_M1;   state_nxt = ST_M2;   end
      ST_M2:   begin cmd.op = OP_M2;   state_nxt = ST_M3;   end
      ST_M3:   begin cmd.op = OP_M3;   state_nxt = ST_TERM; end
      ST_TERM: begin cmd.op = OP_TERM; state_nxt = ST_ACC;  end
      ST_ACC: begin
        cmd.op = OP_ACC;
        if (diag_r && cnt_r != '0) begin
          diag_nxt  = 1'b0;
          state_nxt = ST_M1;
        end else if (!diag_r && ({1'b0, i_r} + 4'd1) < {1'b0, cnt_r}) begin
          i_nxt     = i_r + 3'd1;
          state_nxt = ST_M1;
        end else if (cnt_inc >= dim_eff) begin
          state_nxt = ST_EXP0;
        end else begin
          cnt_nxt   = cnt_r + 3'd1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EXP0: begin cmd.op = OP_EXP0; state_nxt = ST_EXP1; end
      ST_EXP1: begin
        cmd.op    = OP_EXP1;
        b_nxt     = '0;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.op = OP_SCALE;
        b_nxt  = b_r + 3'd1;
        if (b_r == 3'd4) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    cmd.rd_row  = diag_nxt ? cnt_r : i_nxt;
    cmd.rd_col  = cnt_r;
    cmd.idx_j   = cnt_r;
    cmd.idx_i   = i_r;
    cmd.diag    = diag_r;
    cmd.scale_b = b_r;
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dim_r       <= 4'd1;
      cnt_r       <= '0;
      i_r         <= '0;
      diag_r      <= 1'b0;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dim_r       <= dim_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      diag_r      <= diag_nxt;
      b_r         <= b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/gde_dp.sv]
// Datapath of the Gaussian density evaluator: stores, shared multiplier, accumulator, exponential.
module gde_dp
  import gde_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic [IdxW-1:0]     in_row,
  input  logic [IdxW-1:0]     in_col,
  input  logic signed [31:0]  in_value,
  input  logic                cfg_wr,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  output logic [31:0]         out_density,
  output logic                out_saturated
);

  logic [31:0]        mean_r [MaxDim];
  logic [31:0]        prec_mem [MaxDim*MaxDim];
  logic signed [32:0] cent_r [MaxDim];
  logic [31:0]        prec_q_r;
  logic [31:0]        inv_norm_r;
  logic signed [32:0] y_r;
  logic [63:0]        m1_r, lo_r, hi_r;
  logic [31:0]        pm_r;
  logic               sign_r;
  logic signed [63:0] term_r, acc_r, acc_nxt;
  logic [31:0]        interp_r;
  logic [32:0]        e_r;
  logic [31:0]        dens_r;
  logic               sat_r;

  logic [32:0]  mul_a;
  logic [31:0]  mul_b;
  logic [64:0]  mul_p;
  logic signed [32:0] opa, y_new;
  logic [31:0]  mag_a, mag_b, mag_p;
  logic [95:0]  full, shifted;
  logic [62:0]  mag;
  logic [64:0]  sum;
  logic [3:0]   k;
  logic [27:0]  r;
  logic [32:0]  diff;
  logic         neg, big;

  assign opa   = cmd.diag ? y_r : cent_r[cmd.idx_i];
  assign mag_a = opa[32] ? 32'(-opa) : opa[31:0];
  assign mag_b = y_r[32] ? 32'(-y_r) : y_r[31:0];
  assign mag_p = prec_q_r[31] ? (~prec_q_r + 32'd1) : prec_q_r;
  assign y_new = 33'(in_value) - 33'($signed(mean_r[cmd.idx_j]));

  assign k    = acc_r[31:28];
  assign r    = acc_r[27:0];
  assign diff = FRAC_TAB[k] - FRAC_TAB[5'(k) + 5'd1];
  assign neg  = acc_r[63];
  assign big  = |acc_r[62:37];

  always_comb begin
    case (cmd.op)
      OP_M1:    begin mul_a = {1'b0, mag_a};        mul_b = mag_b; end
      OP_M2:    begin mul_a = {1'b0, m1_r[31:0]};   mul_b = pm_r; end
      OP_M3:    begin mul_a = {1'b0, m1_r[63:32]};  mul_b = pm_r; end
      OP_EXP0:  begin mul_a = diff;                 mul_b = {4'd0, r}; end
      OP_SCALE: begin mul_a = e_r;                  mul_b = INT_TAB[cmd.scale_b]; end
      OP_OUT:   begin mul_a = e_r;                  mul_b = inv_norm_r; end
      default:  begin mul_a = '0;                   mul_b = '0; end
    endcase
  end

  assign mul_p = 65'(mul_a) * 65'(mul_b);

  // Term product realigned and clamped to a 63-bit magnitude.
  assign full    = {hi_r, 32'd0} + {32'd0, lo_r};
  assign shifted = cmd.diag ? (full >> 17) : (full >> 16);
  assign mag     = (|shifted[95:63]) ? {63{1'b1}} : shifted[62:0];

  always_comb begin
    sum = {acc_r[63], acc_r} + {term_r[63], term_r};
    if (sum[64] != sum[63]) acc_nxt = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else acc_nxt = sum[63:0];
  end

  always_ff @(posedge clk) begin
    prec_q_r <= prec_mem[{cmd.rd_row, cmd.rd_col}];
    if (cmd.op == OP_LDPREC) prec_mem[{in_row, in_col}] <= in_value;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LDMEAN: mean_r[in_row] <= in_value;
      OP_CENT: begin
        y_r               <= y_new;
        cent_r[cmd.idx_j] <= y_new;
      end
      OP_M1: begin
        m1_r   <= mul_p[63:0];
        pm_r   <= mag_p;
        sign_r <= prec_q_r[31] ^ opa[32] ^ y_r[32];
      end
      OP_M2:   lo_r <= mul_p[63:0];
      OP_M3:   hi_r <= mul_p[63:0];
      OP_TERM: term_r <= sign_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      OP_EXP0: interp_r <= mul_p[59:28];
      OP_EXP1: begin
        if (neg) e_r <= 33'h1_0000_0000;
        else if (big) e_r <= '0;
        else e_r <= FRAC_TAB[k] - {1'b0, interp_r};
      end
      OP_SCALE: begin
        if (!neg && acc_r[6'd32 + 6'(cmd.scale_b)]) e_r <= mul_p[64:32];
      end
      OP_OUT: begin
        dens_r <= mul_p[63:32];
        sat_r  <= neg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      inv_norm_r <= 32'd65536;
    end else begin
      if (cmd.op == OP_ACC) acc_r <= acc_nxt;
      else if (cmd.op == OP_OUT) acc_r <= '0;
      if (cfg_wr && cfg_index == CFG_INV_NORM) inv_norm_r <= cfg_data;
    end
  end

  assign out_density   = dens_r;
  assign out_saturated = sat_r;

endmodule
